// ===== sv/rsi_pkg.sv =====
// Shared constants and types of the ray against sphere intersection core.
// No dependencies; used by rsi_mul and by the top level.
`default_nettype none

package rsi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// operand slice width of the pipelined multiplier
	localparam int MUL_CHUNK = 32;

	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_CENTER_Z,
		CFG_RADIUS
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/rsi_dly.sv =====
// Stallable delay line that keeps side data aligned with the arithmetic units.
// No dependencies.
`default_nettype none

module rsi_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_pass
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] tap_q [DEPTH];

			always_ff @(posedge clk) begin
				if (en) begin
					tap_q[0] <= d;
					for (int k = 1; k < DEPTH; k++) begin
						tap_q[k] <= tap_q[k-1];
					end
				end
			end

			assign q = tap_q[DEPTH-1];
		end
	endgenerate

endmodule

`default_nettype wire

// ===== sv/rsi_mul.sv =====
// Two-stage signed multiplier: slice products in the first stage, their sum in the second.
// Depends on rsi_pkg for the slice width.
`default_nettype none

module rsi_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0]   p
);

	localparam int C  = rsi_pkg::MUL_CHUNK;
	localparam int NA = (AW + C - 1) / C;
	localparam int NB = (BW + C - 1) / C;
	localparam int XA = NA * C;
	localparam int XB = NB * C;
	localparam int FW = XA + XB;

	logic signed [XA-1:0] ax;
	logic signed [XB-1:0] bx;
	wire  signed [C:0]    ac [NA];
	wire  signed [C:0]    bc [NB];

	logic signed [2*C+1:0] pp_s1 [NA][NB];
	logic signed [FW-1:0]  acc;
	logic signed [AW+BW-1:0] p_s2;

	assign ax = XA'(a);
	assign bx = XB'(b);

	// top slice carries the sign, lower slices are unsigned
	genvar g;
	for (g = 0; g < NA; g++) begin : g_ac
		assign ac[g] = (g == NA - 1) ? $signed({ax[g*C+C-1], ax[g*C +: C]})
		                             : $signed({1'b0, ax[g*C +: C]});
	end
	for (g = 0; g < NB; g++) begin : g_bc
		assign bc[g] = (g == NB - 1) ? $signed({bx[g*C+C-1], bx[g*C +: C]})
		                             : $signed({1'b0, bx[g*C +: C]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= ac[i] * bc[j];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (FW'(pp_s1[i][j]) <<< ((i + j) * C));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

// ===== sv/rsi_sqrt.sv =====
// Pipelined floor square root, one result bit per stage (IW/2 stages).
// No dependencies.
`default_nettype none

module rsi_sqrt #(
	parameter int IW = 64
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [IW-1:0]   x,
	output logic      [IW/2-1:0] root
);

	localparam int RW = IW / 2;

	logic [RW+1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [IW-1:0] x_s    [RW];

	logic [RW+1:0] rem_d  [RW];
	logic [RW-1:0] root_d [RW];
	logic [IW-1:0] x_d    [RW];

	always_comb begin
		logic [RW+1:0] rin;
		logic [RW-1:0] rtin;
		logic [IW-1:0] xin;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		for (int k = 0; k < RW; k++) begin
			if (k == 0) begin
				rin  = '0;
				rtin = '0;
				xin  = x;
			end else begin
				rin  = rem_s[k-1];
				rtin = root_s[k-1];
				xin  = x_s[k-1];
			end
			// bring down the next two bits, try root*4+1
			cur   = {rin[RW-1:0], xin[IW-1:IW-2]};
			trial = {rtin, 2'b01};
			if (cur >= trial) begin
				rem_d[k]  = cur - trial;
				root_d[k] = {rtin[RW-2:0], 1'b1};
			end else begin
				rem_d[k]  = cur;
				root_d[k] = {rtin[RW-2:0], 1'b0};
			end
			x_d[k] = xin << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rem_s[k]  <= rem_d[k];
				root_s[k] <= root_d[k];
				x_s[k]    <= x_d[k];
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

`default_nettype wire

// ===== sv/rsi_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage (XW stages).
// No dependencies.
`default_nettype none

module rsi_div #(
	parameter int XW = 64,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [XW-1:0] x,
	input  wire logic [DW-1:0] dv,
	output logic      [XW-1:0] q,
	output logic               rem_nz
);

	logic [DW-1:0] rem_s [XW];
	logic [XW-1:0] xq_s  [XW];
	logic [DW-1:0] dv_s  [XW];

	logic [DW-1:0] rem_d [XW];
	logic [XW-1:0] xq_d  [XW];
	logic [DW-1:0] dv_d  [XW];

	always_comb begin
		logic [DW-1:0] rin;
		logic [XW-1:0] xqin;
		logic [DW-1:0] dvin;
		logic [DW:0]   cur;
		logic          ge;
		for (int k = 0; k < XW; k++) begin
			if (k == 0) begin
				rin  = '0;
				xqin = x;
				dvin = dv;
			end else begin
				rin  = rem_s[k-1];
				xqin = xq_s[k-1];
				dvin = dv_s[k-1];
			end
			// dividend bits leave at the top, quotient bits enter at the bottom
			cur = {rin, xqin[XW-1]};
			ge  = cur >= {1'b0, dvin};
			if (ge) begin
				rem_d[k] = DW'(cur - {1'b0, dvin});
			end else begin
				rem_d[k] = cur[DW-1:0];
			end
			xq_d[k] = {xqin[XW-2:0], ge};
			dv_d[k] = dvin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < XW; k++) begin
				rem_s[k] <= rem_d[k];
				xq_s[k]  <= xq_d[k];
				dv_s[k]  <= dv_d[k];
			end
		end
	end

	assign q      = xq_s[XW-1];
	assign rem_nz = |rem_s[XW-1];

endmodule

`default_nettype wire

// ===== sv/ray_sphere_intersect_core.sv =====
// Ray against sphere intersection core, exact fixed point, fully pipelined.
// Depends on rsi_pkg, rsi_dly, rsi_mul, rsi_sqrt and rsi_div.
//
// Usage: write the sphere centre and radius over the cfg port while no ray
// is in flight; each register takes effect for rays accepted afterwards.
// Rays enter on the s_ stream (origin x,y,z then direction x,y,z in tdata),
// results leave on the m_ stream (distance and normal x,y,z in tdata, the
// hit flag in tuser). One item per cycle is accepted and delivered unless the
// receiver stalls the m_ stream. Most of the pipe is the square root of the
// discriminant (one bit per stage, 2*COORD_WIDTH+2 stages) followed by the
// normal dividers (one quotient bit per stage, 3*COORD_WIDTH+4 stages). All
// stages advance together; when the receiver holds m_tready low with a result
// waiting, the whole pipe holds and s_tready drops, so nothing is lost or
// repeated. Reset empties the pipe and loads centre 0 and radius 1.0; there is
// no clearing pass.
`default_nettype none

module ray_sphere_intersect_core #(
	parameter int  COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
	parameter int  FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF,
	localparam int DIN_W       = ((6 * COORD_WIDTH + 7) / 8) * 8,
	localparam int DOUT_W      = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  wire logic [DIN_W-1:0]               s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// distance, normal_x, normal_y, normal_z
	output logic      [DOUT_W-1:0]              m_tdata,
	// hit
	output logic      [0:0]                     m_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [rsi_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [COORD_WIDTH-1:0]         cfg_wdata
);

	localparam int W  = COORD_WIDTH;
	localparam int AW = 2 * W + 2;   // d.d, kept even for the root
	localparam int BW = 2 * W + 2;   // d.w
	localparam int CW = 2 * W + 3;   // w.w - r*r
	localparam int QW = 4 * W + 4;   // B*B - A*C
	localparam int SW = QW / 2;
	localparam int RW = AW / 2;
	localparam int NW = 2 * W + 4;   // -B - sqrt(Q)
	localparam int PW = W + NW;      // d * N

	localparam int ST_SQ = 7 + SW;
	localparam int ST8   = ST_SQ + 1;
	localparam int ST9   = ST8 + 1;
	localparam int ST10  = ST8 + 3;
	localparam int ST_E  = ST10 + PW;
	localparam int LAT   = ST_E + 2;

	localparam logic [W-2:0] RADIUS_RST = {{(W-2){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [W-1:0] MISS_DIST  = {W{1'b1}} << FRAC_BITS;
	localparam logic [W-1:0] SAT_MAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN    = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0] center_q [3];
	logic [W-2:0]        radius_q;

	logic           en;
	logic [LAT-1:0] vld_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				center_q[k] <= '0;
			end
			radius_q <= RADIUS_RST;
		end else if (cfg_we) begin
			case (rsi_pkg::cfg_reg_t'(cfg_addr))
				rsi_pkg::CFG_CENTER_X: center_q[0] <= cfg_wdata;
				rsi_pkg::CFG_CENTER_Y: center_q[1] <= cfg_wdata;
				rsi_pkg::CFG_CENTER_Z: center_q[2] <= cfg_wdata;
				rsi_pkg::CFG_RADIUS:   radius_q    <= cfg_wdata[W-2:0];
				default: ;
			endcase
		end
	end

	// one shared advance for every stage
	assign m_tvalid = vld_q[LAT-1];
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: w = o - c
	logic signed [W:0]   w_s1 [3];
	logic signed [W-1:0] d_s1 [3];
	logic [W-2:0]        r_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				w_s1[k] <= (W+1)'(signed'(s_tdata[k*W +: W])) - (W+1)'(center_q[k]);
				d_s1[k] <= s_tdata[(3+k)*W +: W];
			end
			r_s1 <= radius_q;
		end
	end

	// stages 2-3: per-axis products
	wire signed [2*W-1:0] dd [3];
	wire signed [2*W:0]   dw [3];
	wire signed [2*W+1:0] ww [3];
	wire signed [2*W-1:0] rr;
	wire signed [W-1:0]   d8 [3];
	wire signed [W:0]     w_e [3];

	genvar g;
	for (g = 0; g < 3; g++) begin : g_axis
		rsi_mul #(.AW(W), .BW(W)) u_dd (
			.clk(clk), .en(en), .a(d_s1[g]), .b(d_s1[g]), .p(dd[g])
		);
		rsi_mul #(.AW(W), .BW(W + 1)) u_dw (
			.clk(clk), .en(en), .a(d_s1[g]), .b(w_s1[g]), .p(dw[g])
		);
		rsi_mul #(.AW(W + 1), .BW(W + 1)) u_ww (
			.clk(clk), .en(en), .a(w_s1[g]), .b(w_s1[g]), .p(ww[g])
		);
		rsi_dly #(.WIDTH(W), .DEPTH(ST8 - 1)) u_d_dly (
			.clk(clk), .en(en), .d(d_s1[g]), .q(d8[g])
		);
		rsi_dly #(.WIDTH(W + 1), .DEPTH(ST_E - 1)) u_w_dly (
			.clk(clk), .en(en), .d(w_s1[g]), .q(w_e[g])
		);
	end

	rsi_mul #(.AW(W), .BW(W)) u_rr (
		.clk(clk), .en(en), .a(signed'({1'b0, r_s1})), .b(signed'({1'b0, r_s1})), .p(rr)
	);

	// stage 4: quadratic coefficients
	logic signed [AW-1:0] a_s4;
	logic signed [BW-1:0] b_s4;
	logic signed [CW-1:0] c_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= AW'(dd[0]) + AW'(dd[1]) + AW'(dd[2]);
			b_s4 <= BW'(dw[0]) + BW'(dw[1]) + BW'(dw[2]);
			c_s4 <= CW'(ww[0]) + CW'(ww[1]) + CW'(ww[2]) - CW'(rr);
		end
	end

	// stages 5-6: B*B and A*C
	wire signed [QW-1:0]    bb;
	wire signed [AW+CW-1:0] ac;
	wire signed [AW-1:0]    a6;
	wire signed [BW-1:0]    b6;

	rsi_mul #(.AW(BW), .BW(BW)) u_bb (.clk(clk), .en(en), .a(b_s4), .b(b_s4), .p(bb));
	rsi_mul #(.AW(AW), .BW(CW)) u_ac (.clk(clk), .en(en), .a(a_s4), .b(c_s4), .p(ac));
	rsi_dly #(.WIDTH(AW), .DEPTH(2)) u_a6 (.clk(clk), .en(en), .d(a_s4), .q(a6));
	rsi_dly #(.WIDTH(BW), .DEPTH(2)) u_b6 (.clk(clk), .en(en), .d(b_s4), .q(b6));

	// stage 7: quarter discriminant and miss
	logic signed [QW-1:0] q_c;
	logic signed [QW-1:0] q_s7;
	logic signed [AW-1:0] a_s7;
	logic signed [BW-1:0] b_s7;
	logic                 miss_s7;

	assign q_c = bb - $signed(ac[QW-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s7    <= q_c;
			a_s7    <= a6;
			b_s7    <= b6;
			miss_s7 <= (a6 == '0) | q_c[QW-1];
		end
	end

	// square roots of Q and A
	wire [SW-1:0]         s_root;
	wire [RW-1:0]         ra;
	wire [RW-1:0]         ra9;
	wire signed [BW-1:0]  b_sq;
	wire [AW-1:0]         a10;
	wire                  miss_e;

	rsi_sqrt #(.IW(QW)) u_sq_q (.clk(clk), .en(en), .x(q_s7), .root(s_root));
	rsi_sqrt #(.IW(AW)) u_sq_a (.clk(clk), .en(en), .x(a_s7), .root(ra));
	rsi_dly #(.WIDTH(RW), .DEPTH(ST9 - 7 - RW)) u_ra_dly (
		.clk(clk), .en(en), .d(ra), .q(ra9)
	);
	rsi_dly #(.WIDTH(BW), .DEPTH(SW)) u_b_dly (.clk(clk), .en(en), .d(b_s7), .q(b_sq));
	rsi_dly #(.WIDTH(AW), .DEPTH(ST10 - 7)) u_a_dly (.clk(clk), .en(en), .d(a_s7), .q(a10));
	rsi_dly #(.WIDTH(1), .DEPTH(ST_E - 7)) u_miss_dly (
		.clk(clk), .en(en), .d(miss_s7), .q(miss_e)
	);

	// stage 8: N = -B - sqrt(Q)
	logic signed [NW-1:0] n_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s8 <= -NW'(b_sq) - NW'(s_root);
		end
	end

	// stage 9: magnitude of N for the distance divide
	logic [NW-1:0] nmag_s9;
	logic          nneg_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s9 <= n_s8[NW-1] ? NW'(-n_s8) : NW'(n_s8);
			nneg_s9 <= n_s8[NW-1];
		end
	end

	wire [NW-1:0] qd;
	wire          qd_nz;
	wire [NW-1:0] qd_e;
	wire          qd_nz_e;
	wire          nneg_e;

	rsi_div #(.XW(NW), .DW(RW)) u_div_dist (
		.clk(clk), .en(en), .x(nmag_s9), .dv(ra9), .q(qd), .rem_nz(qd_nz)
	);
	rsi_dly #(.WIDTH(NW + 1), .DEPTH(ST_E - ST9 - NW)) u_qd_dly (
		.clk(clk), .en(en), .d({qd_nz, qd}), .q({qd_nz_e, qd_e})
	);
	rsi_dly #(.WIDTH(1), .DEPTH(ST_E - ST9)) u_nneg_dly (
		.clk(clk), .en(en), .d(nneg_s9), .q(nneg_e)
	);

	// d * N, then magnitude at stage 10, then floor(d*N / A)
	wire signed [PW-1:0] p [3];
	logic [PW-1:0]       pmag_s10 [3];
	logic                pneg_s10 [3];
	wire [PW-1:0]        qn [3];
	wire                 qn_nz [3];
	wire                 pneg_e [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pmag_s10[k] <= p[k][PW-1] ? PW'(-p[k]) : PW'(p[k]);
				pneg_s10[k] <= p[k][PW-1];
			end
		end
	end

	for (g = 0; g < 3; g++) begin : g_norm
		rsi_mul #(.AW(W), .BW(NW)) u_p (.clk(clk), .en(en), .a(d8[g]), .b(n_s8), .p(p[g]));
		rsi_div #(.XW(PW), .DW(AW)) u_div_n (
			.clk(clk), .en(en), .x(pmag_s10[g]), .dv(a10), .q(qn[g]), .rem_nz(qn_nz[g])
		);
		rsi_dly #(.WIDTH(1), .DEPTH(PW)) u_pneg_dly (
			.clk(clk), .en(en), .d(pneg_s10[g]), .q(pneg_e[g])
		);
	end

	// stage 11: signed floor quotients; -(q + nz) = ~q + !nz
	logic signed [NW:0]   dq_s11;
	logic signed [PW:0]   nq_s11 [3];
	logic signed [W:0]    w_s11 [3];
	logic                 miss_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s11 <= nneg_e ? (~{1'b0, qd_e}) + (NW+1)'(!qd_nz_e) : {1'b0, qd_e};
			for (int k = 0; k < 3; k++) begin
				nq_s11[k] <= pneg_e[k] ? (~{1'b0, qn[k]}) + (PW+1)'(!qn_nz[k])
				                       : {1'b0, qn[k]};
				w_s11[k]  <= w_e[k];
			end
			miss_s11 <= miss_e;
		end
	end

	// stage 12: add w, saturate, select the miss result
	logic [W-1:0]        dist_sat;
	logic [W-1:0]        nrm_sat [3];
	logic signed [PW+1:0] hp [3];

	always_comb begin
		if ((&dq_s11[NW:W-1]) | ~(|dq_s11[NW:W-1])) begin
			dist_sat = dq_s11[W-1:0];
		end else begin
			dist_sat = dq_s11[NW] ? SAT_MIN : SAT_MAX;
		end
		for (int k = 0; k < 3; k++) begin
			hp[k] = (PW+2)'(nq_s11[k]) + (PW+2)'(w_s11[k]);
			if ((&hp[k][PW+1:W-1]) | ~(|hp[k][PW+1:W-1])) begin
				nrm_sat[k] = hp[k][W-1:0];
			end else begin
				nrm_sat[k] = hp[k][PW+1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	logic         hit_s12;
	logic [W-1:0] dist_s12;
	logic [W-1:0] nrm_s12 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s12  <= ~miss_s11;
			dist_s12 <= miss_s11 ? MISS_DIST : dist_sat;
			for (int k = 0; k < 3; k++) begin
				nrm_s12[k] <= miss_s11 ? '0 : nrm_sat[k];
			end
		end
	end

	assign m_tdata = DOUT_W'({nrm_s12[2], nrm_s12[1], nrm_s12[0], dist_s12});
	assign m_tuser = hit_s12;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for ray_sphere_intersect_core: streams rays, predicts each
// intersection result in wide integer arithmetic and compares on the output stream.
// Depends on rsi_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

class hit_scoreboard;
	typedef struct packed {
		logic        hit;
		logic [31:0] distance;
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
	} hit_t;

	logic signed [31:0] cen[3];
	logic [30:0]        radius;
	hit_t               pending[$];
	int                 errors;

	function new();
		cen[0] = 0;
		cen[1] = 0;
		cen[2] = 0;
		radius = 31'd65536;
		errors = 0;
	endfunction

	static function logic signed [255:0] floor_div(logic signed [255:0] n,
			logic signed [255:0] d);
		logic signed [255:0] q;
		q = n / d;
		if (n < 0 && q * d != n)
			q = q - 1;
		return q;
	endfunction

	static function logic signed [255:0] isqrt(logic signed [255:0] a);
		logic signed [255:0] r;
		logic signed [255:0] cand;
		r = 0;
		for (int i = 127; i >= 0; i--) begin
			cand = r | (256'sd1 <<< i);
			if (cand * cand <= a)
				r = cand;
		end
		return r;
	endfunction

	static function logic [31:0] sat32(logic signed [255:0] v);
		if (v > 256'sd2147483647)
			return 32'h7fffffff;
		if (v < -256'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function void note_ray(logic [191:0] ray);
		logic signed [255:0] d[3];
		logic signed [255:0] w[3];
		logic signed [255:0] a, b, c, q, s, ra, n, r;
		hit_t e;
		a = 0;
		b = 0;
		c = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = $signed(ray[32*i +: 32]) - cen[i];
			d[i] = $signed(ray[96 + 32*i +: 32]);
			a = a + d[i] * d[i];
			b = b + d[i] * w[i];
			c = c + w[i] * w[i];
		end
		r = {225'd0, radius};
		c = c - r * r;
		q = b * b - a * c;
		if (a == 0 || q < 0) begin
			e = '{hit: 1'b0, distance: 32'hffff0000, nx: '0, ny: '0, nz: '0};
		end else begin
			s = isqrt(q);
			ra = isqrt(a);
			n = -b - s;
			e.hit = 1'b1;
			e.distance = sat32(floor_div(n, ra));
			e.nx = sat32(floor_div(d[0] * n, a) + w[0]);
			e.ny = sat32(floor_div(d[1] * n, a) + w[1]);
			e.nz = sat32(floor_div(d[2] * n, a) + w[2]);
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic [127:0] data, logic hit);
		hit_t e;
		if (pending.size() == 0) begin
			$error("unexpected result item");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (hit !== e.hit) begin
			$error("hit: expected %0d actual %0d", e.hit, hit);
			errors++;
		end
		if (data[31:0] !== e.distance) begin
			$error("distance: expected %h actual %h", e.distance, data[31:0]);
			errors++;
		end
		if (data[63:32] !== e.nx) begin
			$error("normal_x: expected %h actual %h", e.nx, data[63:32]);
			errors++;
		end
		if (data[95:64] !== e.ny) begin
			$error("normal_y: expected %h actual %h", e.ny, data[95:64]);
			errors++;
		end
		if (data[127:96] !== e.nz) begin
			$error("normal_z: expected %h actual %h", e.nz, data[127:96]);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int LATENCY = 179;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_we;
	logic [rsi_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [31:0]  cfg_wdata;

	int send_idle_pct;
	int stall_pct;
	int hold_off_cycles;

	hit_scoreboard sb;

	ray_sphere_intersect_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL ray_sphere_intersect_core");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser[0]);
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rsi_pkg::CFG_CENTER_X: sb.cen[0] = val;
			rsi_pkg::CFG_CENTER_Y: sb.cen[1] = val;
			rsi_pkg::CFG_CENTER_Z: sb.cen[2] = val;
			default:               sb.radius = val[30:0];
		endcase
		@(posedge clk);
	endtask

	task automatic send_ray(logic [191:0] ray);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_ray(ray);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
		endcase
	endfunction

	// random ray; in three cases of four, aimed roughly at the center from a random origin
	function automatic logic [191:0] rand_ray();
		logic [191:0] ray;
		logic signed [31:0] o, c;
		for (int i = 0; i < 6; i++)
			ray[32*i +: 32] = rand_coord();
		if ($urandom_range(3) != 0) begin
			for (int i = 0; i < 3; i++) begin
				o = $signed($urandom_range(40 * 65536)) - 20 * 65536;
				c = sb.cen[i];
				ray[32*i +: 32] = o;
				ray[96 + 32*i +: 32] = (c - o) + ($signed($urandom_range(65536)) - 32768);
			end
		end
		return ray;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_ray(rand_ray());
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = rsi_pkg::CFG_CENTER_X;
		cfg_wdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unit sphere at origin
		send_ray({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd327680}); // miss, origin offset along x
		send_ray({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});                 // zero direction
		send_ray({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0});   // tangent
		send_ray({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd131072, 32'sd0});  // miss
		send_ray({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});       // from center
		send_ray({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd327680});  // miss, origin offset along x
		send_ray({6{32'h7fffffff}});
		send_ray({6{32'h80000000}});
		send_ray({{3{32'h80000000}}, {3{32'h7fffffff}}});
		send_ray({{3{32'h7fffffff}}, {3{32'h80000000}}});
		send_ray({6{32'hffffffff}});
		send_ray({32'sd1, 32'sd0, 32'sd0, 32'h7fffffff, 32'sd0, 32'sd0});
		drain();

		write_reg(rsi_pkg::CFG_RADIUS, 32'h7fffffff);
		write_reg(rsi_pkg::CFG_CENTER_X, 32'h80000000);
		write_reg(rsi_pkg::CFG_CENTER_Y, 32'h7fffffff);
		write_reg(rsi_pkg::CFG_CENTER_Z, 32'h0);
		send_ray({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0});
		send_ray({6{32'h7fffffff}});
		send_ray({6{32'h80000000}});
		drain();
		write_reg(rsi_pkg::CFG_RADIUS, 32'h0);
		write_reg(rsi_pkg::CFG_CENTER_Y, 32'h0);
		write_reg(rsi_pkg::CFG_CENTER_X, 32'h0);
		send_ray({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, -32'sd65536}); // point sphere
		send_ray({32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
		drain();

		// random phases with varied idling and sphere settings
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(rsi_pkg::CFG_CENTER_X, $signed($urandom_range(8 * 65536)) - 4 * 65536);
			write_reg(rsi_pkg::CFG_CENTER_Y, $urandom_range(3) == 0 ? $urandom() :
				$signed($urandom_range(8 * 65536)) - 4 * 65536);
			write_reg(rsi_pkg::CFG_CENTER_Z, $signed($urandom_range(8 * 65536)) - 4 * 65536);
			write_reg(rsi_pkg::CFG_RADIUS, ph == 3 ? $urandom() : $urandom_range(8 * 65536));
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 33) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 33) : 0;
			run_random(60);
			send_idle_pct = 0;
			stall_pct = 0;
			run_random(20);
			if (ph == 0)
				hold_off_cycles = 700;
			run_random(40);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS ray_sphere_intersect_core");
		else
			$display("FAIL ray_sphere_intersect_core");
		$finish;
	end
endmodule

`default_nettype wire
